@@ sv/mmt_pkg.sv @@
// package of the maximal munch tokenizer: widths, token kinds, character classes
package mmt_pkg;

  // widths
  localparam int unsigned OffsetBits   = 16;
  localparam int unsigned CharBits     = 8;
  localparam int unsigned KindBits     = 5;
  localparam int unsigned StartBits    = 16;
  localparam int unsigned LenBits      = 16;
  localparam int unsigned QueueDepth   = 4;
  localparam int unsigned QueuePtrBits = $clog2(QueueDepth);
  localparam int unsigned QueueCntBits = QueuePtrBits + 1;

  localparam logic [LenBits-1:0] LenMax = '1;

  // special characters
  localparam logic [CharBits-1:0] CharNul        = 8'h00;
  localparam logic [CharBits-1:0] CharUnderscore = 8'h5f;
  localparam logic [CharBits-1:0] CharBang       = 8'h21;
  localparam logic [CharBits-1:0] CharLess       = 8'h3c;
  localparam logic [CharBits-1:0] CharGreater    = 8'h3e;
  localparam logic [CharBits-1:0] CharEqual      = 8'h3d;

  // pending operator codes
  localparam logic [1:0] OpBang    = 2'd0;
  localparam logic [1:0] OpLess    = 2'd1;
  localparam logic [1:0] OpGreater = 2'd2;
  localparam logic [1:0] OpEqual   = 2'd3;

  // token kinds
  localparam logic [KindBits-1:0] KindEof       = 5'd0;
  localparam logic [KindBits-1:0] KindIdent     = 5'd1;
  localparam logic [KindBits-1:0] KindNumber    = 5'd2;
  localparam logic [KindBits-1:0] KindBang      = 5'd3;
  localparam logic [KindBits-1:0] KindBangEq    = 5'd4;
  localparam logic [KindBits-1:0] KindComma     = 5'd11;
  localparam logic [KindBits-1:0] KindSemicolon = 5'd12;
  localparam logic [KindBits-1:0] KindRBrace    = 5'd13;
  localparam logic [KindBits-1:0] KindLBrace    = 5'd14;
  localparam logic [KindBits-1:0] KindLParen    = 5'd15;
  localparam logic [KindBits-1:0] KindRParen    = 5'd16;
  localparam logic [KindBits-1:0] KindRBracket  = 5'd17;
  localparam logic [KindBits-1:0] KindLBracket  = 5'd18;
  localparam logic [KindBits-1:0] KindPlus      = 5'd19;
  localparam logic [KindBits-1:0] KindSlash     = 5'd20;
  localparam logic [KindBits-1:0] KindAsterisk  = 5'd21;
  localparam logic [KindBits-1:0] KindMinus     = 5'd22;
  localparam logic [KindBits-1:0] KindUnknown   = 5'd23;

  // one result token
  typedef struct packed {
    logic [KindBits-1:0]  kind;
    logic [StartBits-1:0] start;
    logic [LenBits-1:0]   length;
    logic                 last;
  } tok_t;

  // tokens produced by one byte, first goes out first
  typedef struct packed {
    logic [1:0] cnt;
    tok_t       first;
    tok_t       second;
  } push_t;

  function automatic logic is_space(input logic [CharBits-1:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0a) || (c == 8'h0d) ||
           (c == 8'h0b) || (c == 8'h0c);
  endfunction

  function automatic logic is_word(input logic [CharBits-1:0] c);
    return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a)) ||
           (c == CharUnderscore);
  endfunction

  function automatic logic is_decimal(input logic [CharBits-1:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_oper(input logic [CharBits-1:0] c);
    return (c == CharBang) || (c == CharLess) || (c == CharGreater) || (c == CharEqual);
  endfunction

  function automatic logic [1:0] oper_code(input logic [CharBits-1:0] c);
    logic [1:0] code;
    priority if (c == CharBang)    code = OpBang;
    else if     (c == CharLess)    code = OpLess;
    else if     (c == CharGreater) code = OpGreater;
    else                           code = OpEqual;
    return code;
  endfunction

  // single character punctuators, anything else is unknown
  function automatic logic [KindBits-1:0] punct_kind(input logic [CharBits-1:0] c);
    logic [KindBits-1:0] k;
    unique case (c)
      8'h2c:   k = KindComma;
      8'h3b:   k = KindSemicolon;
      8'h7d:   k = KindRBrace;
      8'h7b:   k = KindLBrace;
      8'h28:   k = KindLParen;
      8'h29:   k = KindRParen;
      8'h5d:   k = KindRBracket;
      8'h5b:   k = KindLBracket;
      8'h2b:   k = KindPlus;
      8'h2f:   k = KindSlash;
      8'h2a:   k = KindAsterisk;
      8'h2d:   k = KindMinus;
      default: k = KindUnknown;
    endcase
    return k;
  endfunction

endpackage

@@ sv/mmt_char_if.sv @@
// byte channel carrying source text
interface mmt_char_if;
  import mmt_pkg::*;

  logic                valid;
  logic                ready;
  logic [CharBits-1:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

@@ sv/mmt_token_if.sv @@
// token channel carrying result tokens
interface mmt_token_if;
  import mmt_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [KindBits-1:0]  token_kind;
  logic [StartBits-1:0] token_start;
  logic [LenBits-1:0]   token_length;
  logic                 last;

  modport source (output valid, output token_kind, output token_start,
                  output token_length, output last, input ready);
  modport sink   (input valid, input token_kind, input token_start,
                  input token_length, input last, output ready);
endinterface

@@ sv/mmt_front.sv @@
// front end: accepts bytes, classifies them and runs the scan state
module mmt_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  mmt_char_if.sink        in_i,
  input  logic            room_i,
  output mmt_pkg::push_t  push_o
);
  import mmt_pkg::*;

  localparam logic [1:0] ModeIdle   = 2'd0;
  localparam logic [1:0] ModeIdent  = 2'd1;
  localparam logic [1:0] ModeNumber = 2'd2;
  localparam logic [1:0] ModeOper   = 2'd3;

  logic [1:0]            mode_q, mode_d;
  logic [1:0]            op_q, op_d;
  logic [OffsetBits-1:0] begin_q, begin_d;
  logic [OffsetBits-1:0] offset_q, offset_d;
  logic [LenBits-1:0]    len_q, len_d;

  logic                  accept;
  logic [CharBits-1:0]   c;
  logic                  c_space, c_zero;
  logic [LenBits-1:0]    len_grown;

  logic                  f_emit, f_begin;
  logic [1:0]            f_mode, f_op;
  tok_t                  f_tok;
  logic                  p_emit, use_fresh, emit_fresh;
  tok_t                  p_tok;

  assign in_i.ready = room_i;
  assign accept     = in_i.valid && room_i;
  assign c          = in_i.char_code;
  assign c_space    = is_space(c);
  assign c_zero     = (c == CharNul);
  assign len_grown  = (len_q != LenMax) ? len_q + 1'b1 : len_q;

  // handling of a byte that starts from idle
  always_comb begin
    f_emit       = 1'b0;
    f_begin      = 1'b0;
    f_mode       = ModeIdle;
    f_op         = op_q;
    f_tok.kind   = KindEof;
    f_tok.start  = StartBits'(offset_q);
    f_tok.length = LenBits'(1);
    f_tok.last   = 1'b1;
    priority if (c_space) begin
    end else if (c_zero) begin
      f_emit = 1'b1;
    end else begin
      f_begin = 1'b1;
      priority if (is_word(c)) begin
        f_mode = ModeIdent;
      end else if (is_decimal(c)) begin
        f_mode = ModeNumber;
      end else if (is_oper(c)) begin
        f_mode = ModeOper;
        f_op   = oper_code(c);
      end else begin
        f_emit     = 1'b1;
        f_tok.kind = punct_kind(c);
      end
    end
  end

  // pending token and next scan state
  always_comb begin
    mode_d       = mode_q;
    op_d         = op_q;
    begin_d      = begin_q;
    len_d        = len_q;
    p_emit       = 1'b0;
    use_fresh    = 1'b0;
    p_tok.kind   = KindIdent;
    p_tok.start  = StartBits'(begin_q);
    p_tok.length = len_q;
    p_tok.last   = 1'b1;
    unique case (mode_q)
      ModeIdent, ModeNumber: begin
        if ((mode_q == ModeIdent) ? is_word(c) : is_decimal(c)) begin
          len_d = len_grown;
        end else begin
          p_emit     = 1'b1;
          p_tok.kind = (mode_q == ModeIdent) ? KindIdent : KindNumber;
          use_fresh  = 1'b1;
        end
      end
      ModeOper: begin
        if (c_space) begin
          len_d = len_grown;
        end else if (c == CharEqual) begin
          len_d        = len_grown;
          p_emit       = 1'b1;
          p_tok.kind   = KindBangEq + KindBits'({op_q, 1'b0});
          p_tok.length = len_grown;
          mode_d       = ModeIdle;
        end else begin
          p_emit       = 1'b1;
          p_tok.kind   = KindBang + KindBits'({op_q, 1'b0});
          p_tok.length = LenBits'(1);
          use_fresh    = 1'b1;
        end
      end
      default: begin
        use_fresh = 1'b1;
      end
    endcase
    if (use_fresh) begin
      mode_d = f_mode;
      op_d   = f_op;
      if (f_begin) begin
        begin_d = offset_q;
        len_d   = LenBits'(1);
      end
    end
    // end of text clears the run and restarts the offset
    if (c_zero) begin
      mode_d   = ModeIdle;
      len_d    = '0;
      offset_d = '0;
    end else begin
      offset_d = offset_q + 1'b1;
    end
  end

  // tokens handed to the queue
  assign emit_fresh = use_fresh && f_emit;
  always_comb begin
    push_o.cnt    = accept ? 2'(p_emit) + 2'(emit_fresh) : 2'd0;
    push_o.first  = p_emit ? p_tok : f_tok;
    push_o.second = f_tok;
    push_o.first.last = !(p_emit && emit_fresh);
  end

  // scan state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= ModeIdle;
      op_q     <= OpBang;
      begin_q  <= '0;
      offset_q <= '0;
      len_q    <= '0;
    end else if (accept) begin
      mode_q   <= mode_d;
      op_q     <= op_d;
      begin_q  <= begin_d;
      offset_q <= offset_d;
      len_q    <= len_d;
    end
  end

  // a running token always has a nonzero length
  a_run_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q != ModeIdle) |-> (len_q != '0))
    else $error("running token with zero length");

  // an accepted end of text restarts the offset
  a_eof_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && c_zero) |=> (offset_q == '0))
    else $error("offset not cleared after end of text");

endmodule

@@ sv/mmt_queue.sv @@
// back end: token queue between scanner and output channel
module mmt_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mmt_pkg::push_t  push_i,
  output logic            room_o,
  mmt_token_if.source     out_o
);
  import mmt_pkg::*;

  tok_t                    mem_q [QueueDepth];
  logic [QueuePtrBits-1:0] wr_q, rd_q;
  logic [QueueCntBits-1:0] count_q, count_d;
  logic                    pop;
  tok_t                    head;

  // head entry drives the channel
  assign head               = mem_q[rd_q];
  assign out_o.valid        = (count_q != '0);
  assign out_o.token_kind   = head.kind;
  assign out_o.token_start  = head.start;
  assign out_o.token_length = head.length;
  assign out_o.last         = head.last;
  assign pop                = out_o.valid && out_o.ready;

  // room for the two tokens one byte may cause
  assign room_o  = (count_q <= QueueCntBits'(QueueDepth - 2));
  assign count_d = count_q + QueueCntBits'(push_i.cnt) - QueueCntBits'(pop);

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_q] <= push_i.first;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_q + 1'b1] <= push_i.second;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_q + QueuePtrBits'(push_i.cnt);
      rd_q    <= rd_q + QueuePtrBits'(pop);
      count_q <= count_d;
    end
  end

  // never more tokens than entries
  a_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QueueCntBits'(QueueDepth))
    else $error("token queue overflow");

  // a pair of tokens is pushed only into room for both
  a_pair_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.cnt == 2'd2) |-> (room_o && !push_i.first.last))
    else $error("token pair pushed without room or with early last");

endmodule

@@ sv/maximal_munch_tokenizer_unit.sv @@
// Maximal munch tokenizer: takes one source byte per cycle and emits
// identifier, number, operator and punctuator tokens with start offset and
// length. A byte is taken in every cycle in which the token queue has two free
// entries; each byte leaves zero, one or two tokens there, and the output side
// delivers one token per cycle, so text streams at one byte per cycle while
// the output keeps up. The scanner state and the four-entry token queue set
// this figure. A zero byte flushes any pending token, emits end of text and
// restarts the offset at zero.
module maximal_munch_tokenizer_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  mmt_char_if.sink     in_i,
  mmt_token_if.source  out_o
);
  import mmt_pkg::*;

  push_t push;
  logic  room;

  // scanner
  mmt_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .room_i (room),
    .push_o (push)
  );

  // token queue and output channel
  mmt_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room_o (room),
    .out_o  (out_o)
  );

endmodule
